[sv/vns_pkg.sv]
// shared types and codes for the voronoi nearest-site block
package vns_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_RELAX  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_NUM_SITES   = 2'd2;

    // query scans: centre, then four neighbours
    localparam logic [2:0] LAST_QUERY_PASS = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SC_RD,
        ST_SC_DX,
        ST_SC_DY,
        ST_SC_CMP,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_UPD_RD,
        ST_UPD_WAIT,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DONE
    } state_t;

endpackage

[sv/vns_ram.sv]
// generic single write port ram with registered read
module vns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/vns_div.sv]
// restoring divider, one quotient bit per cycle
module vns_div #(
    parameter int N_W = 38,
    parameter int D_W = 21
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     rem_sh;
    logic             fits;

    assign rem_sh   = {rem_reg, quo_reg[N_W-1]};
    assign fits     = (rem_sh >= {1'b0, divisor});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= D_W'(rem_sh - {1'b0, divisor});
                quo_reg <= {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b0};
            end
        end
    end

endmodule

[sv/voronoi_nearest_site_lloyd_relax.sv]
// top level of the voronoi nearest-site block with lloyd relaxation
// A query runs five nearest-site scans (the pixel and its four neighbours) through one
// shared squaring multiplier. A relax request first clears all MAX_SITES entries of the
// accumulator ram, then scans and accumulates every pixel of the grid, then moves each
// non-empty site with two runs of the bit-serial divider. The block takes one request at
// a time; s_tready is low from acceptance until the result of the request has moved
// into the output register.
module voronoi_nearest_site_lloyd_relax import vns_pkg::*; #(
    parameter int MAX_SITES = 64,
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // site_index[5:0], coord_x[15:6], coord_y[25:16], zero
    input  logic [1:0]  s_tuser,    // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // nearest_site[5:0], on_border[6], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int IDX_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int NS_W   = $clog2(MAX_SITES + 1);
    localparam int CW     = $clog2(MAX_DIM);
    localparam int DW_W   = $clog2(MAX_DIM + 1);
    localparam int CRD_W  = (CW > 10) ? CW : 10;
    localparam int PX_W   = CRD_W + 2;
    localparam int POS_W  = CRD_W + FRAC_BITS;
    localparam int DX_W   = POS_W + 3;
    localparam int SQ_W   = 2 * DX_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int SUM_W  = 3 * CW;
    localparam int CNT_W  = 2 * CW + 1;
    localparam int ACC_W  = 2 * SUM_W + CNT_W;
    localparam int DVD_W  = SUM_W + FRAC_BITS;

    state_t state_reg, state_next;

    // configuration registers
    logic [10:0]      grid_width_reg, grid_height_reg;
    logic [6:0]       num_sites_reg;
    logic [DW_W-1:0]  w_eff, h_eff;
    logic [NS_W-1:0]  n_eff;

    // request fields
    logic [5:0]       in_site_index;
    logic [9:0]       in_coord_x, in_coord_y;
    logic             accept;

    // scan datapath
    logic [IDX_W-1:0]        scan_i_reg, best_reg, upd_i_reg, best_now;
    logic signed [PX_W-1:0]  px_reg, py_reg, cx_reg, cy_reg;
    logic [2:0]              pass_reg;
    logic                    query_reg, border_reg;
    logic [IDX_W-1:0]        centre_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIST_W-1:0]       dist_reg, best_d_reg;
    logic signed [DX_W-1:0]  px_sc, py_sc, dx, dy, mul_in;
    logic signed [SQ_W-1:0]  sq;
    logic                    take, scan_last, col_last, row_last, upd_last;

    // memories
    logic                    site_we;
    logic [IDX_W-1:0]        site_waddr;
    logic [2*POS_W-1:0]      site_wdata, site_rdata;
    logic [POS_W-1:0]        site_x, site_y, qx_reg;
    logic                    acc_we;
    logic [IDX_W-1:0]        acc_waddr, acc_raddr;
    logic [ACC_W-1:0]        acc_wdata, acc_rdata;
    logic [SUM_W-1:0]        acc_sx, acc_sy;
    logic [CNT_W-1:0]        acc_cnt;

    // divider
    logic                    div_start, div_done;
    logic [DVD_W-1:0]        div_dividend, div_quo;

    // result
    logic                    out_valid_reg;
    logic [7:0]              out_data_reg;

    assign in_site_index = s_tdata[5:0];
    assign in_coord_x    = s_tdata[15:6];
    assign in_coord_y    = s_tdata[25:16];
    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    assign cfg_ready     = 1'b1;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    // out of range register values clamp to the legal span
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = DW_W'(1);
        else if (32'(grid_width_reg) > MAX_DIM)
            w_eff = DW_W'(MAX_DIM);
        else
            w_eff = DW_W'(grid_width_reg);
        if (grid_height_reg == '0)
            h_eff = DW_W'(1);
        else if (32'(grid_height_reg) > MAX_DIM)
            h_eff = DW_W'(MAX_DIM);
        else
            h_eff = DW_W'(grid_height_reg);
        if (num_sites_reg == '0)
            n_eff = NS_W'(1);
        else if (32'(num_sites_reg) > MAX_SITES)
            n_eff = NS_W'(MAX_SITES);
        else
            n_eff = NS_W'(num_sites_reg);
    end

    // site table, {y, x} in fixed point
    assign site_x = site_rdata[POS_W-1:0];
    assign site_y = site_rdata[2*POS_W-1:POS_W];

    always_comb
    begin
        if (state_reg == ST_DIV_Y)
        begin
            site_we    = div_done;
            site_waddr = upd_i_reg;
            site_wdata = {POS_W'(div_quo), qx_reg};
        end
        else
        begin
            site_we    = accept && (s_tuser == FUNC_LOAD) && (32'(in_site_index) < MAX_SITES);
            site_waddr = IDX_W'(in_site_index);
            site_wdata = {POS_W'(in_coord_y) << FRAC_BITS, POS_W'(in_coord_x) << FRAC_BITS};
        end
    end

    vns_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_SITES)) u_site_ram (
        .clk   (clk),
        .we    (site_we),
        .waddr (site_waddr),
        .wdata (site_wdata),
        .raddr (scan_i_reg),
        .rdata (site_rdata)
    );

    // accumulators, {count, sum_y, sum_x}
    assign acc_sx  = acc_rdata[SUM_W-1:0];
    assign acc_sy  = acc_rdata[2*SUM_W-1:SUM_W];
    assign acc_cnt = acc_rdata[ACC_W-1:2*SUM_W];

    always_comb
    begin
        acc_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ACC_WR);
        acc_waddr = (state_reg == ST_CLEAR) ? upd_i_reg : best_reg;
        acc_raddr = ((state_reg == ST_ACC_RD) || (state_reg == ST_ACC_WR)) ? best_reg : upd_i_reg;
        if (state_reg == ST_CLEAR)
            acc_wdata = '0;
        else
            acc_wdata = {acc_cnt + CNT_W'(1),
                         acc_sy + SUM_W'(py_reg[CW-1:0]),
                         acc_sx + SUM_W'(px_reg[CW-1:0])};
    end

    vns_ram #(.WIDTH(ACC_W), .DEPTH(MAX_SITES)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // centroid divider, x then y
    assign div_start    = ((state_reg == ST_UPD_WAIT) && (acc_cnt != '0)) ||
                          ((state_reg == ST_DIV_X) && div_done);
    assign div_dividend = (state_reg == ST_DIV_X) ? (DVD_W'(acc_sy) << FRAC_BITS)
                                                  : (DVD_W'(acc_sx) << FRAC_BITS);

    vns_div #(.N_W(DVD_W), .D_W(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (acc_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    // shared squarer: dx in one cycle, dy in the next
    assign px_sc  = DX_W'(px_reg) <<< FRAC_BITS;
    assign py_sc  = DX_W'(py_reg) <<< FRAC_BITS;
    assign dx     = px_sc - $signed({3'b000, site_x});
    assign dy     = py_sc - $signed({3'b000, site_y});
    assign mul_in = (state_reg == ST_SC_DX) ? dx : dy;
    assign sq     = mul_in * mul_in;

    // first strict minimum wins
    assign take      = (scan_i_reg == '0) || (dist_reg < best_d_reg);
    assign best_now  = take ? scan_i_reg : best_reg;
    assign scan_last = ({1'b0, scan_i_reg} == NS_W'(n_eff - 1'b1));
    assign upd_last  = ({1'b0, upd_i_reg} == NS_W'(n_eff - 1'b1));
    assign col_last  = (px_reg[CW-1:0] == CW'(w_eff - 1'b1));
    assign row_last  = (py_reg[CW-1:0] == CW'(h_eff - 1'b1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_QUERY)
                        state_next = ST_SC_RD;
                    else if (s_tuser == FUNC_RELAX)
                        state_next = ST_CLEAR;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                if (32'(upd_i_reg) == MAX_SITES - 1)
                    state_next = ST_SC_RD;
            end
            ST_SC_RD:  state_next = ST_SC_DX;
            ST_SC_DX:  state_next = ST_SC_DY;
            ST_SC_DY:  state_next = ST_SC_CMP;
            ST_SC_CMP:
            begin
                if (!scan_last)
                    state_next = ST_SC_RD;
                else if (!query_reg)
                    state_next = ST_ACC_RD;
                else if (pass_reg == LAST_QUERY_PASS)
                    state_next = ST_DONE;
                else
                    state_next = ST_SC_RD;
            end
            ST_ACC_RD: state_next = ST_ACC_WR;
            ST_ACC_WR:
            begin
                if (col_last && row_last)
                    state_next = ST_UPD_RD;
                else
                    state_next = ST_SC_RD;
            end
            ST_UPD_RD: state_next = ST_UPD_WAIT;
            ST_UPD_WAIT:
            begin
                if (acc_cnt != '0)
                    state_next = ST_DIV_X;
                else if (upd_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_UPD_RD;
            end
            ST_DIV_X:
            begin
                if (div_done)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (div_done)
                    state_next = upd_last ? ST_DONE : ST_UPD_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            grid_width_reg  <= 11'd256;
            grid_height_reg <= 11'd256;
            num_sites_reg   <= 7'd16;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    CFG_NUM_SITES:   num_sites_reg   <= cfg_data[6:0];
                    default:         ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    query_reg  <= (s_tuser == FUNC_QUERY);
                    pass_reg   <= '0;
                    border_reg <= 1'b0;
                    centre_reg <= '0;
                    scan_i_reg <= '0;
                    upd_i_reg  <= '0;
                    if (s_tuser == FUNC_QUERY)
                    begin
                        px_reg <= PX_W'(in_coord_x);
                        py_reg <= PX_W'(in_coord_y);
                    end
                    else
                    begin
                        px_reg <= '0;
                        py_reg <= '0;
                    end
                    cx_reg <= PX_W'(in_coord_x);
                    cy_reg <= PX_W'(in_coord_y);
                end
            end
            ST_CLEAR:
            begin
                upd_i_reg <= upd_i_reg + 1'b1;
            end
            ST_SC_DX:
            begin
                sq_reg <= $unsigned(sq);
            end
            ST_SC_DY:
            begin
                dist_reg <= DIST_W'(sq_reg) + DIST_W'($unsigned(sq));
            end
            ST_SC_CMP:
            begin
                if (take)
                begin
                    best_d_reg <= dist_reg;
                    best_reg   <= scan_i_reg;
                end
                if (!scan_last)
                    scan_i_reg <= scan_i_reg + 1'b1;
                else
                begin
                    scan_i_reg <= '0;
                    if (query_reg)
                    begin
                        if (pass_reg == '0)
                            centre_reg <= best_now;
                        else if (best_now != centre_reg)
                            border_reg <= 1'b1;
                        pass_reg <= pass_reg + 1'b1;
                        // neighbour order: left, right, up, down
                        case (pass_reg)
                            3'd0:
                            begin
                                px_reg <= cx_reg - 1'b1;
                                py_reg <= cy_reg;
                            end
                            3'd1:
                            begin
                                px_reg <= cx_reg + 1'b1;
                                py_reg <= cy_reg;
                            end
                            3'd2:
                            begin
                                px_reg <= cx_reg;
                                py_reg <= cy_reg - 1'b1;
                            end
                            default:
                            begin
                                px_reg <= cx_reg;
                                py_reg <= cy_reg + 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_ACC_WR:
            begin
                if (col_last)
                begin
                    px_reg <= '0;
                    py_reg <= py_reg + 1'b1;
                end
                else
                    px_reg <= px_reg + 1'b1;
                upd_i_reg <= '0;
            end
            ST_UPD_WAIT:
            begin
                if ((acc_cnt == '0) && !upd_last)
                    upd_i_reg <= upd_i_reg + 1'b1;
            end
            ST_DIV_X:
            begin
                if (div_done)
                    qx_reg <= POS_W'(div_quo);
            end
            ST_DIV_Y:
            begin
                if (div_done && !upd_last)
                    upd_i_reg <= upd_i_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if ((state_reg == ST_DONE) && (!out_valid_reg || m_tready))
        begin
            if (query_reg)
                out_data_reg <= {1'b0, border_reg, 6'(centre_reg)};
            else
                out_data_reg <= '0;
        end
    end

endmodule
